// ----- design/bba_pkg.sv -----
package bba_pkg;

   // Width of one word of the usage map, held by one cell of the ring.
   localparam int WORD_W   = 32;
   localparam int BITSEL_W = 5;

   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_CLAIM   = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;
   localparam logic [1:0] OP_QUERY   = 2'd3;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_IN_USE = 2'd2;
   localparam logic [1:0] ST_RANGE  = 2'd3;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] block_index;
   } bba_req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] granted_block;
      logic [8:0] used_count;
      logic [8:0] free_count;
   } bba_rsp_type;

   // Control handed to the head unit for the word now at the front of the ring.
   typedef struct packed {
      logic [1:0]          op;
      logic                target_word;
      logic [BITSEL_W-1:0] bit_sel;
      logic                alloc_open;
   } bba_head_ctl_type;

   // What the head unit did to that word.
   typedef struct packed {
      logic                set_done;
      logic                clr_done;
      logic                in_use;
      logic [BITSEL_W-1:0] bit_pos;
   } bba_head_res_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_PUSH
   } bba_fsm_type;

endpackage

// ----- design/bitmap_block_allocator.sv -----
// Channel  Direction  Beat type      Meaning
// req_     in         bba_req_type   opcode and block index of one request
// rsp_     out        bba_rsp_type   status, granted block, used and free counts
//
// Allocate, claim and release rotate the usage map once around the ring of
// word cells (8 words at 256 blocks), then load the output register. A query
// skips the ring and goes straight to the output register load.
// Reset is synchronous and restores the map with the two reserved blocks set.
// A stalled result sits in the output register; the next request is taken in
// the cycle that result leaves, or whenever the block is idle.
module bitmap_block_allocator import bba_pkg::*; #(
   parameter int NUM_BLOCKS     = 256,
   parameter int RESERVED_FIRST = 127
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  bba_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output bba_rsp_type rsp_data
);

   // The map is held as a ring of 32-bit words. Bits past the last block are
   // parked as used so that allocation never picks them; they are not counted.
   localparam int NUM_WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
   localparam int CNT_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int BLK_W     = CNT_W + BITSEL_W;
   localparam int USED_W    = $clog2(NUM_BLOCKS + 1);
   localparam int RES_USED  = ((RESERVED_FIRST < NUM_BLOCKS) ? 1 : 0) +
                              ((RESERVED_FIRST + 1 < NUM_BLOCKS) ? 1 : 0);

   function automatic logic [WORD_W-1:0] word_init(input int k);
      logic [WORD_W-1:0] w;
      int                blk;
      w = '0;
      for (int b = 0; b < WORD_W; b++) begin
         blk = k * WORD_W + b;
         if (blk >= NUM_BLOCKS || blk == RESERVED_FIRST || blk == RESERVED_FIRST + 1) begin
            w[b] = 1'b1;
         end
      end
      return w;
   endfunction

   // Control state
   bba_fsm_type        state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [USED_W-1:0]  used_ff, used_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               found_ff, found_in;

   // Request context and result being built
   logic [1:0]         op_ff, op_in;
   logic [7:0]         idx_ff, idx_in;
   logic               idx_ok_ff, idx_ok_in;
   logic [1:0]         status_ff, status_in;
   logic [7:0]         granted_ff, granted_in;
   bba_rsp_type        rsp_data_ff, rsp_data_in;

   // FSM outputs
   logic               shift_en;
   logic               push;
   logic               last_word;
   logic               out_free;
   logic               accept;
   logic               req_in_range;

   logic [WORD_W-1:0]  ring [NUM_WORDS];
   logic [WORD_W-1:0]  head_word;
   bba_head_ctl_type   head_ctl;
   bba_head_res_type   head_res;
   logic [BLK_W-1:0]   head_blk;

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign accept       = req_valid && req_ready;
   assign last_word    = (cnt_ff == CNT_W'(NUM_WORDS - 1));
   assign req_in_range = (32'(req_data.block_index) < NUM_BLOCKS);

   // The ring: every cell takes its upper neighbor's word, and the last cell
   // takes the word that the head unit has just worked on.
   for (genvar k = 0; k < NUM_WORDS; k++) begin : g_cell
      logic [WORD_W-1:0] nb_word;
      if (k == NUM_WORDS - 1) begin : g_tail
         assign nb_word = head_word;
      end else begin : g_mid
         assign nb_word = ring[k+1];
      end
      bba_cell #(
         .RESET_VALUE (word_init(k))
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .word_in  (nb_word),
         .word_out (ring[k])
      );
   end

   // The cell at the front of the ring always holds word number cnt_ff.
   assign head_ctl.op          = op_ff;
   assign head_ctl.target_word = idx_ok_ff && (32'(idx_ff[7:BITSEL_W]) == 32'(cnt_ff));
   assign head_ctl.bit_sel     = idx_ff[BITSEL_W-1:0];
   assign head_ctl.alloc_open  = !found_ff;

   bba_head u_head (
      .word_in  (ring[0]),
      .ctl      (head_ctl),
      .word_out (head_word),
      .res      (head_res)
   );

   assign head_blk = {cnt_ff, head_res.bit_pos};

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               state_in = (req_data.opcode == OP_QUERY) ? FSM_PUSH : FSM_SCAN;
            end
         end
         FSM_SCAN: begin
            if (last_word) begin
               state_in = FSM_PUSH;
            end
         end
         FSM_PUSH: begin
            if (accept) begin
               state_in = (req_data.opcode == OP_QUERY) ? FSM_PUSH : FSM_SCAN;
            end else if (out_free) begin
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // FSM outputs.
   always_comb begin
      shift_en  = 1'b0;
      push      = 1'b0;
      req_ready = 1'b0;
      case (state_ff)
         FSM_IDLE: begin
            req_ready = 1'b1;
         end
         FSM_SCAN: begin
            shift_en = 1'b1;
         end
         FSM_PUSH: begin
            push      = out_free;
            req_ready = out_free;
         end
         default: begin
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      cnt_in      = cnt_ff;
      used_in     = used_ff;
      found_in    = found_ff;
      op_in       = op_ff;
      idx_in      = idx_ff;
      idx_ok_in   = idx_ok_ff;
      status_in   = status_ff;
      granted_in  = granted_ff;
      rsp_data_in = rsp_data_ff;

      if (shift_en) begin
         cnt_in = last_word ? '0 : cnt_ff + CNT_W'(1);
         if (head_res.set_done) begin
            used_in    = used_ff + USED_W'(1);
            found_in   = 1'b1;
            status_in  = ST_OK;
            granted_in = 8'(head_blk);
         end
         if (head_res.clr_done) begin
            used_in = used_ff - USED_W'(1);
         end
         if (head_res.in_use) begin
            status_in = ST_IN_USE;
         end
      end

      if (push) begin
         rsp_data_in.status        = status_ff;
         rsp_data_in.granted_block = granted_ff;
         rsp_data_in.used_count    = 9'(used_ff);
         rsp_data_in.free_count    = 9'(USED_W'(NUM_BLOCKS) - used_ff);
      end

      // A new request starts with the status it has unless the scan says otherwise.
      if (accept) begin
         cnt_in     = '0;
         found_in   = 1'b0;
         op_in      = req_data.opcode;
         idx_in     = req_data.block_index;
         idx_ok_in  = req_in_range;
         granted_in = '0;
         case (req_data.opcode)
            OP_ALLOC: begin
               status_in = ST_FULL;
            end
            OP_CLAIM, OP_RELEASE: begin
               status_in = req_in_range ? ST_OK : ST_RANGE;
            end
            default: begin
               status_in = ST_OK;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         cnt_ff       <= '0;
         used_ff      <= USED_W'(RES_USED);
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      idx_ff      <= idx_in;
      idx_ok_ff   <= idx_ok_in;
      status_ff   <= status_in;
      granted_ff  <= granted_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- design/bba_cell.sv -----
module bba_cell import bba_pkg::*; #(
   parameter logic [WORD_W-1:0] RESET_VALUE = '0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift_en,
   input  logic [WORD_W-1:0] word_in,
   output logic [WORD_W-1:0] word_out
);

   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_next_in;

   // Takes the neighbor's word on every step of the ring.
   assign word_next_in = shift_en ? word_in : word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= RESET_VALUE;
      end else begin
         word_ff <= word_next_in;
      end
   end

   assign word_out = word_ff;

endmodule

// ----- design/bba_head.sv -----
module bba_head import bba_pkg::*; (
   input  logic [WORD_W-1:0] word_in,
   input  bba_head_ctl_type  ctl,
   output logic [WORD_W-1:0] word_out,
   output bba_head_res_type  res
);

   logic [WORD_W-1:0]   free_bits;
   logic [WORD_W-1:0]   lowest_free;
   logic [BITSEL_W-1:0] lowest_pos;
   logic                sel_bit;

   assign free_bits   = ~word_in;
   assign lowest_free = free_bits & (~free_bits + WORD_W'(1));
   assign sel_bit     = word_in[ctl.bit_sel];

   always_comb begin
      lowest_pos = '0;
      for (int b = 0; b < WORD_W; b++) begin
         if (lowest_free[b]) begin
            lowest_pos = lowest_pos | BITSEL_W'(b);
         end
      end
   end

   always_comb begin
      word_out     = word_in;
      res.set_done = 1'b0;
      res.clr_done = 1'b0;
      res.in_use   = 1'b0;
      res.bit_pos  = ctl.bit_sel;
      case (ctl.op)
         OP_ALLOC: begin
            if (ctl.alloc_open && (|free_bits)) begin
               word_out     = word_in | lowest_free;
               res.set_done = 1'b1;
               res.bit_pos  = lowest_pos;
            end
         end
         OP_CLAIM: begin
            if (ctl.target_word) begin
               if (sel_bit) begin
                  res.in_use = 1'b1;
               end else begin
                  word_out[ctl.bit_sel] = 1'b1;
                  res.set_done          = 1'b1;
               end
            end
         end
         OP_RELEASE: begin
            if (ctl.target_word && sel_bit) begin
               word_out[ctl.bit_sel] = 1'b0;
               res.clr_done          = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

endmodule
